// ===== hdl/euler_to_rotation_basis_defines.svh =====
// Assertion macros for the RTL top level
`ifndef EULER_TO_ROTATION_BASIS_DEFINES_SVH
`define EULER_TO_ROTATION_BASIS_DEFINES_SVH

// same-cycle implication, quiet while reset is high
`define ERTB_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, quiet while reset is high
`define ERTB_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/ertb_pkg.sv =====
`default_nettype none

package ertb_pkg;

   // angle, fraction and table geometry
   localparam int ANGLE_BITS      = 16;
   localparam int FRAC_BITS       = 14;
   localparam int TABLE_ADDR_BITS = 10;

   localparam int QTR_ENTRIES = 1 << TABLE_ADDR_BITS;
   localparam int ROM_W       = FRAC_BITS + 1;   // unsigned table entry, 0 .. one
   localparam int FIX_W       = FRAC_BITS + 2;   // signed value, -one .. one
   localparam int PROD_W      = 2 * FIX_W;
   localparam int SUM_W       = FIX_W + 1;
   localparam int OUT_W       = 16;              // fixed field width on the bus
   localparam int IDX_W       = TABLE_ADDR_BITS + 1;
   localparam int PH_W        = ANGLE_BITS - 2 + TABLE_ADDR_BITS + 1;

   localparam int ONE_FIX    = 1 << FRAC_BITS;
   localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);

   localparam logic [IDX_W-1:0]        QTR_IDX = IDX_W'(QTR_ENTRIES);
   localparam logic [PH_W-1:0]         IDX_RND = PH_W'(1) << (ANGLE_BITS - 3);
   localparam logic signed [SUM_W-1:0] SAT_HI  = SUM_W'(ONE_FIX);
   localparam logic signed [SUM_W-1:0] SAT_LO  = -SAT_HI;
   localparam logic signed [OUT_W-1:0] OUT_HI  = OUT_W'(ONE_FIX);
   localparam logic signed [OUT_W-1:0] OUT_LO  = -OUT_HI;

   // pi/2 in Q62
   localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

   typedef logic [QTR_ENTRIES:0][ROM_W-1:0] rom_type;

   // load strobes for the two register stages of a sine/cosine unit
   typedef struct packed {
      logic load_idx;
      logic load_trig;
   } sc_ctrl_type;

   // (a * b) >> 62, truncated to 64 bits
   function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = 128'(a) * 128'(b);
      return p[125:62];
   endfunction

   // quarter-wave sine table, integer Taylor series in Q62, rounded to FRAC_BITS
   function automatic rom_type build_rom();
      rom_type     r;
      logic [63:0] hi_part;
      logic [63:0] lo_part;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] rnd;
      hi_part = HALF_PI_Q62 >> TABLE_ADDR_BITS;
      lo_part = HALF_PI_Q62 & 64'(QTR_ENTRIES - 1);
      for (int k = 0; k <= QTR_ENTRIES; k++) begin
         x    = hi_part * 64'(k) + ((lo_part * 64'(k)) >> TABLE_ADDR_BITS);
         x2   = mul_q62(x, x);
         term = x;
         sum  = x;
         for (int n = 1; n <= 13; n++) begin
            term = mul_q62(term, x2) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
         rnd  = (sum + (64'(1) << (61 - FRAC_BITS))) >> (62 - FRAC_BITS);
         r[k] = rnd[ROM_W-1:0];
      end
      return r;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   // product of two fixed values, rounded half up (floor of product plus half)
   function automatic logic signed [FIX_W-1:0] fmul(logic signed [FIX_W-1:0] a,
                                                    logic signed [FIX_W-1:0] b);
      logic signed [PROD_W-1:0] p;
      p = PROD_W'(a) * PROD_W'(b);
      p = p + PROD_W'(ROUND_HALF);
      p = p >>> FRAC_BITS;
      return p[FIX_W-1:0];
   endfunction

   // sign-extend a fixed value to the sum width
   function automatic logic signed [SUM_W-1:0] ext(logic signed [FIX_W-1:0] v);
      return SUM_W'(v);
   endfunction

   // clamp to plus or minus one, then cut to the bus field
   function automatic logic [OUT_W-1:0] sat_out(logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] c;
      logic signed [63:0]      w;
      c = v;
      if (v > SAT_HI) begin
         c = SAT_HI;
      end
      if (v < SAT_LO) begin
         c = SAT_LO;
      end
      w = 64'(c);
      return w[OUT_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== hdl/ertb_sincos.sv =====
`default_nettype none

// Sine and cosine of one binary angle: index rounding, then table read and sign
module ertb_sincos (
   input  wire                                   clock,
   input  wire ertb_pkg::sc_ctrl_type            ctrl,
   input  wire [ertb_pkg::ANGLE_BITS-1:0]        angle,
   output logic signed [ertb_pkg::FIX_W-1:0]     sin_val,
   output logic signed [ertb_pkg::FIX_W-1:0]     cos_val
);

   logic [ertb_pkg::PH_W-1:0]        phase_scaled;
   logic [ertb_pkg::IDX_W-1:0]       idx_raw;
   logic [ertb_pkg::IDX_W-1:0]       idx_in, idx_ff;
   logic [1:0]                       quad_in, quad_ff;
   logic [1:0]                       quad_c;
   logic [ertb_pkg::IDX_W-1:0]       idx_comp;
   logic [ertb_pkg::ROM_W-1:0]       mag_fwd, mag_rev, mag_s, mag_c;
   logic signed [ertb_pkg::FIX_W-1:0] sin_in, sin_ff, cos_in, cos_ff;

   // round the phase within the quadrant to the nearest table index
   always_comb begin
      phase_scaled = (ertb_pkg::PH_W'(angle[ertb_pkg::ANGLE_BITS-3:0])
                      << ertb_pkg::TABLE_ADDR_BITS) + ertb_pkg::IDX_RND;
      idx_raw = phase_scaled[ertb_pkg::PH_W-1:ertb_pkg::ANGLE_BITS-2];
      idx_in  = (idx_raw > ertb_pkg::QTR_IDX) ? ertb_pkg::QTR_IDX : idx_raw;
      quad_in = angle[ertb_pkg::ANGLE_BITS-1:ertb_pkg::ANGLE_BITS-2];
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_idx) begin
         idx_ff  <= idx_in;
         quad_ff <= quad_in;
      end
   end

   // table reads; odd quadrants run the table backwards, cosine is a quarter on
   always_comb begin
      idx_comp = ertb_pkg::QTR_IDX - idx_ff;
      mag_fwd  = ertb_pkg::SINE_ROM[idx_ff];
      mag_rev  = ertb_pkg::SINE_ROM[idx_comp];
      quad_c   = quad_ff + 2'd1;
      mag_s    = quad_ff[0] ? mag_rev : mag_fwd;
      mag_c    = quad_c[0]  ? mag_rev : mag_fwd;
      sin_in   = quad_ff[1] ? -ertb_pkg::FIX_W'(mag_s) : ertb_pkg::FIX_W'(mag_s);
      cos_in   = quad_c[1]  ? -ertb_pkg::FIX_W'(mag_c) : ertb_pkg::FIX_W'(mag_c);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_trig) begin
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

   assign sin_val = sin_ff;
   assign cos_val = cos_ff;

endmodule

`default_nettype wire

// ===== hdl/euler_to_rotation_basis.sv =====
`default_nettype none
`include "euler_to_rotation_basis_defines.svh"

// Yaw, pitch and roll (binary angles, 65536 units a turn) in, the nine elements of
// the forward, left and up basis vectors out in signed Q1.14, clamped to plus or
// minus one. A new angle word is taken every clock unless back-pressure fills the
// pipeline, and its result passes through registered stages: index rounding,
// quarter-wave table read (1025 entries, one registered read per sine and cosine), a
// rank of ten 16x16 products, the second products with the pitch-roll terms, and the
// sums with saturation. Each stage holds its word while the one after it is full and
// stalled, so bubbles close up under back-pressure. The table is a constant; nothing but the valid bits is reset.
module euler_to_rotation_basis (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   // yaw_angle [15:0], pitch_angle [31:16], roll_angle [47:32]
   input  wire  [47:0]  req_tdata,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // fwd_x, fwd_y, fwd_z, left_x, left_y, left_z, up_x, up_y, up_z, 16 bits each
   output logic [143:0] rsp_tdata
);

   localparam int FW = ertb_pkg::FIX_W;
   localparam int OW = ertb_pkg::OUT_W;

   typedef struct packed {
      logic signed [FW-1:0] cycp, sycp, sycr, cycr, cpsr, sysr, cysr, cpcr;
      logic signed [FW-1:0] pr, pc, cy, sy, sp;
   } s3_type;

   typedef struct packed {
      logic signed [FW-1:0] cycp, sycp, sycr, cycr, cpsr, sysr, cysr, cpcr;
      logic signed [FW-1:0] cypr, sypr, cypc, sypc, sp;
   } s4_type;

   typedef struct packed {
      logic [OW-1:0] up_z, up_y, up_x, left_z, left_y, left_x, fwd_z, fwd_y, fwd_x;
   } s5_type;

   logic v1_in, v1_ff, v2_in, v2_ff, v3_in, v3_ff, v4_in, v4_ff, v5_in, v5_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5;

   ertb_pkg::sc_ctrl_type sc_ctrl;
   logic signed [FW-1:0]  sy, cy, sp, cp, sr, cr;

   s3_type s3_in, s3_ff;
   s4_type s4_in, s4_ff;
   s5_type s5_in, s5_ff;

   // stage readiness: a stage takes a word when empty or when it passes its own on
   always_comb begin
      rdy5 = !v5_ff || rsp_tready;
      rdy4 = !v4_ff || rdy5;
      rdy3 = !v3_ff || rdy4;
      rdy2 = !v2_ff || rdy3;
      rdy1 = !v1_ff || rdy2;
   end

   always_comb begin
      v1_in = rdy1 ? req_tvalid : v1_ff;
      v2_in = rdy2 ? v1_ff : v2_ff;
      v3_in = rdy3 ? v2_ff : v3_ff;
      v4_in = rdy4 ? v3_ff : v4_ff;
      v5_in = rdy5 ? v4_ff : v5_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
         v5_ff <= v5_in;
      end
   end

   assign req_tready = rdy1;

   // stages one and two: sine and cosine of each angle
   assign sc_ctrl = '{load_idx: rdy1, load_trig: rdy2};

   ertb_sincos u_yaw (
      .clock   (clock),
      .ctrl    (sc_ctrl),
      .angle   (req_tdata[15:0]),
      .sin_val (sy),
      .cos_val (cy)
   );

   ertb_sincos u_pitch (
      .clock   (clock),
      .ctrl    (sc_ctrl),
      .angle   (req_tdata[31:16]),
      .sin_val (sp),
      .cos_val (cp)
   );

   ertb_sincos u_roll (
      .clock   (clock),
      .ctrl    (sc_ctrl),
      .angle   (req_tdata[47:32]),
      .sin_val (sr),
      .cos_val (cr)
   );

   // stage three: first rank of rounded products
   always_comb begin
      s3_in.cycp = ertb_pkg::fmul(cy, cp);
      s3_in.sycp = ertb_pkg::fmul(sy, cp);
      s3_in.sycr = ertb_pkg::fmul(sy, cr);
      s3_in.cycr = ertb_pkg::fmul(cy, cr);
      s3_in.cpsr = ertb_pkg::fmul(cp, sr);
      s3_in.sysr = ertb_pkg::fmul(sy, sr);
      s3_in.cysr = ertb_pkg::fmul(cy, sr);
      s3_in.cpcr = ertb_pkg::fmul(cp, cr);
      s3_in.pr   = ertb_pkg::fmul(sp, sr);
      s3_in.pc   = ertb_pkg::fmul(sp, cr);
      s3_in.cy   = cy;
      s3_in.sy   = sy;
      s3_in.sp   = sp;
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         s3_ff <= s3_in;
      end
   end

   // stage four: yaw terms times the rounded pitch-roll products
   always_comb begin
      s4_in.cycp = s3_ff.cycp;
      s4_in.sycp = s3_ff.sycp;
      s4_in.sycr = s3_ff.sycr;
      s4_in.cycr = s3_ff.cycr;
      s4_in.cpsr = s3_ff.cpsr;
      s4_in.sysr = s3_ff.sysr;
      s4_in.cysr = s3_ff.cysr;
      s4_in.cpcr = s3_ff.cpcr;
      s4_in.cypr = ertb_pkg::fmul(s3_ff.cy, s3_ff.pr);
      s4_in.sypr = ertb_pkg::fmul(s3_ff.sy, s3_ff.pr);
      s4_in.cypc = ertb_pkg::fmul(s3_ff.cy, s3_ff.pc);
      s4_in.sypc = ertb_pkg::fmul(s3_ff.sy, s3_ff.pc);
      s4_in.sp   = s3_ff.sp;
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         s4_ff <= s4_in;
      end
   end

   // stage five: exact sums, clamp, cut to the bus fields
   always_comb begin
      s5_in.fwd_x  = ertb_pkg::sat_out(ertb_pkg::ext(s4_ff.cycp));
      s5_in.fwd_y  = ertb_pkg::sat_out(ertb_pkg::ext(s4_ff.sycp));
      s5_in.fwd_z  = ertb_pkg::sat_out(-ertb_pkg::ext(s4_ff.sp));
      s5_in.left_x = ertb_pkg::sat_out(ertb_pkg::ext(s4_ff.cypr) - ertb_pkg::ext(s4_ff.sycr));
      s5_in.left_y = ertb_pkg::sat_out(ertb_pkg::ext(s4_ff.cycr) + ertb_pkg::ext(s4_ff.sypr));
      s5_in.left_z = ertb_pkg::sat_out(ertb_pkg::ext(s4_ff.cpsr));
      s5_in.up_x   = ertb_pkg::sat_out(ertb_pkg::ext(s4_ff.sysr) + ertb_pkg::ext(s4_ff.cypc));
      s5_in.up_y   = ertb_pkg::sat_out(ertb_pkg::ext(s4_ff.sypc) - ertb_pkg::ext(s4_ff.cysr));
      s5_in.up_z   = ertb_pkg::sat_out(ertb_pkg::ext(s4_ff.cpcr));
   end

   always_ff @(posedge clock) begin
      if (rdy5) begin
         s5_ff <= s5_in;
      end
   end

   assign rsp_tvalid = v5_ff;
   assign rsp_tdata  = s5_ff;

   // an accepted word is held in the first stage on the next cycle
   `ERTB_ASSERT_NXT(a_accept_fills, clock, reset, req_tvalid && req_tready, v1_ff, "accepted word not captured")

   // a taken result with nothing behind it leaves the output empty
   `ERTB_ASSERT_NXT(a_drain, clock, reset, rsp_tvalid && rsp_tready && !v4_ff, !rsp_tvalid, "result repeated")

   // the summed left_x element never leaves the unit range
   `ERTB_ASSERT_IMP(a_sat_left_x, clock, reset, rsp_tvalid, ($signed(s5_ff.left_x) <= ertb_pkg::OUT_HI) && ($signed(s5_ff.left_x) >= ertb_pkg::OUT_LO), "left_x beyond one")

endmodule

`default_nettype wire

// ===== dv/tb_euler_to_rotation_basis.sv =====
module tb_euler_to_rotation_basis;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          ANGLE_BITS      = ertb_pkg::ANGLE_BITS;
   localparam int          FRAC_BITS       = ertb_pkg::FRAC_BITS;
   localparam int          TABLE_ADDR_BITS = ertb_pkg::TABLE_ADDR_BITS;
   localparam int          QTR_ENTRIES     = ertb_pkg::QTR_ENTRIES;
   localparam int          ONE_FIX         = ertb_pkg::ONE_FIX;
   localparam logic [63:0] HALF_PI_Q62     = ertb_pkg::HALF_PI_Q62;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RESET_CYCLES = 8;
   localparam int DRAIN_CYCLES = 16;
   localparam int HOLD_CYCLES  = 80;

   // request word, yaw in the low bits
   typedef struct packed {
      logic [15:0] roll;
      logic [15:0] pitch;
      logic [15:0] yaw;
   } angle_triple_type;

   // result word, element 0 (fwd_x) in the low bits
   typedef enum int {
      FWD_X, FWD_Y, FWD_Z, LEFT_X, LEFT_Y, LEFT_Z, UP_X, UP_Y, UP_Z
   } basis_field_type;
   typedef logic [8:0][15:0] basis_word_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [47:0]   req_tdata = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [143:0]  rsp_tdata;

   longint         sine_quarter [0:QTR_ENTRIES];
   basis_word_type basis_q [$];
   int             mismatch_count = 0;
   int             cycle_count = 0;
   int             send_idle_pct = 0;
   int             rcv_stall_pct = 0;
   bit             hold_request = 1'b0;
   int             hold_left = 0;

   euler_to_rotation_basis u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   // (a * b) >> 62, kept to 64 bits
   function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[125:62];
   endfunction

   // quarter-wave sine, Taylor series in Q62, rounded to the fraction width
   function automatic void fill_sine_quarter();
      logic [63:0] step_hi;
      logic [63:0] step_lo;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] acc;
      step_hi = HALF_PI_Q62 >> TABLE_ADDR_BITS;
      step_lo = HALF_PI_Q62 & 64'(QTR_ENTRIES - 1);
      for (int k = 0; k <= QTR_ENTRIES; k++) begin
         x    = step_hi * 64'(k) + ((step_lo * 64'(k)) >> TABLE_ADDR_BITS);
         x2   = q62_mul(x, x);
         term = x;
         acc  = x;
         for (int n = 1; n <= 13; n++) begin
            term = q62_mul(term, x2) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
               acc = acc - term;
            end else begin
               acc = acc + term;
            end
         end
         sine_quarter[k] = longint'((acc + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS));
      end
   endfunction

   // sine, or cosine when cosine is set (angle plus a quarter turn)
   function automatic longint trig_lookup(input logic [15:0] ang, input bit cosine);
      int unsigned quad;
      longint      phase;
      longint      idx;
      longint      mag;
      quad  = (32'(ang >> (ANGLE_BITS - 2)) + 32'(cosine)) & 32'd3;
      phase = longint'(ang) & ((longint'(1) << (ANGLE_BITS - 2)) - 1);
      idx   = ((phase << TABLE_ADDR_BITS) + (longint'(1) << (ANGLE_BITS - 3)))
              >> (ANGLE_BITS - 2);
      if (idx > QTR_ENTRIES) begin
         idx = QTR_ENTRIES;
      end
      mag = quad[0] ? sine_quarter[QTR_ENTRIES - idx] : sine_quarter[idx];
      return quad[1] ? -mag : mag;
   endfunction

   // product rounded half up: floor of (a*b + half)
   function automatic longint fix_mul(input longint a, input longint b);
      longint w;
      w = a * b + (longint'(1) << (FRAC_BITS - 1));
      return w >>> FRAC_BITS;
   endfunction

   function automatic logic [15:0] clamp_one(input longint v);
      longint c;
      c = v;
      if (c > ONE_FIX) begin
         c = ONE_FIX;
      end
      if (c < -ONE_FIX) begin
         c = -ONE_FIX;
      end
      return c[15:0];
   endfunction

   function automatic basis_word_type predict_basis(input angle_triple_type a);
      basis_word_type b;
      longint         cy, sy, cp, sp, cr, sr, sp_sr, sp_cr;
      cy    = trig_lookup(a.yaw, 1'b1);
      sy    = trig_lookup(a.yaw, 1'b0);
      cp    = trig_lookup(a.pitch, 1'b1);
      sp    = trig_lookup(a.pitch, 1'b0);
      cr    = trig_lookup(a.roll, 1'b1);
      sr    = trig_lookup(a.roll, 1'b0);
      // pitch-roll terms are rounded before the yaw product
      sp_sr = fix_mul(sp, sr);
      sp_cr = fix_mul(sp, cr);
      b[FWD_X]  = clamp_one(fix_mul(cy, cp));
      b[FWD_Y]  = clamp_one(fix_mul(sy, cp));
      b[FWD_Z]  = clamp_one(-sp);
      b[LEFT_X] = clamp_one(-fix_mul(sy, cr) + fix_mul(cy, sp_sr));
      b[LEFT_Y] = clamp_one(fix_mul(cy, cr) + fix_mul(sy, sp_sr));
      b[LEFT_Z] = clamp_one(fix_mul(cp, sr));
      b[UP_X]   = clamp_one(fix_mul(sy, sr) + fix_mul(cy, sp_cr));
      b[UP_Y]   = clamp_one(-fix_mul(cy, sr) + fix_mul(sy, sp_cr));
      b[UP_Z]   = clamp_one(fix_mul(cp, cr));
      return b;
   endfunction

   // ---------------------------------------------------------------- driving

   // called at a falling edge, returns at a falling edge with valid still high
   task automatic send_angles(input logic [15:0] yaw, input logic [15:0] pitch,
                              input logic [15:0] roll);
      angle_triple_type w;
      int               gap;
      w.yaw   = yaw;
      w.pitch = pitch;
      w.roll  = roll;
      gap = 0;
      while (gap < 40 && $urandom_range(0, 99) < send_idle_pct) begin
         gap++;
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      basis_q.push_back(predict_basis(w));
      @(negedge clock);
   endtask

   // biased angle: full range, near quarter turns, or on an index rounding tie
   function automatic logic [15:0] pick_angle();
      logic [15:0] a;
      case ($urandom_range(0, 3))
         0, 1: begin
            a = 16'($urandom);
         end
         2: begin
            a = 16'($urandom_range(0, 3) << 14) + 16'($urandom_range(0, 32)) - 16'd16;
         end
         default: begin
            a = {12'($urandom), 4'h8};
         end
      endcase
      return a;
   endfunction

   task automatic wait_for_drain();
      while (basis_q.size() != 0) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   // receiver: random stalls, or a counted hold-off when requested
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left    = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left  = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rcv_stall_pct);
      end
   end

   // ---------------------------------------------------------------- checking

   always @(posedge clock) begin : check_results
      basis_word_type  want;
      basis_word_type  got;
      basis_field_type fld;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (basis_q.size() == 0) begin
            $display("%0t: result word with nothing expected, actual %h", $time, got);
            mismatch_count++;
         end else begin
            want = basis_q.pop_front();
            for (int f = 0; f < 9; f++) begin
               fld = basis_field_type'(f);
               if (got[f] !== want[f]) begin
                  $display("%0t: %s expected %0d actual %0d", $time, fld.name(),
                           $signed(want[f]), $signed(got[f]));
                  mismatch_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ---------------------------------------------------------------- tests

   // extremes, quarter turns, gimbal lock, rounding ties and table top
   task automatic test_directed_angles();
      send_idle_pct = 10;
      rcv_stall_pct = 10;
      send_angles(16'h0000, 16'h0000, 16'h0000);
      send_angles(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_angles(16'h4000, 16'h0000, 16'h0000);
      send_angles(16'h8000, 16'h0000, 16'h0000);
      send_angles(16'hC000, 16'h0000, 16'h0000);
      send_angles(16'h0000, 16'h4000, 16'h0000);
      send_angles(16'h0000, 16'hC000, 16'h0000);
      send_angles(16'h0000, 16'h0000, 16'h4000);
      send_angles(16'h0000, 16'h0000, 16'h8000);
      send_angles(16'h2000, 16'h4000, 16'h6000);
      send_angles(16'h1234, 16'hC000, 16'h8765);
      send_angles(16'h0008, 16'h0018, 16'h0028);
      send_angles(16'h3FF8, 16'h7FF8, 16'hBFF8);
      send_angles(16'h3FFF, 16'h7FFF, 16'hBFFF);
      send_angles(16'h2000, 16'h2000, 16'h2000);
      send_angles(16'hE000, 16'h2000, 16'hA000);
      send_angles(16'h6000, 16'hE000, 16'h2000);
      send_angles(16'hAAAA, 16'h5555, 16'hAAAA);
      send_angles(16'h5555, 16'hAAAA, 16'h5555);
      send_angles(16'h0001, 16'h8001, 16'hFFF8);
   endtask

   task automatic test_random_angles(input int count, input int send_pct, input int rcv_pct);
      send_idle_pct = send_pct;
      rcv_stall_pct = rcv_pct;
      repeat (count) begin
         send_angles(pick_angle(), pick_angle(), pick_angle());
      end
   endtask

   // long output hold-off while words keep coming, so the pipeline fills
   task automatic test_output_hold_off();
      send_idle_pct = 0;
      rcv_stall_pct = 0;
      hold_request  = 1'b1;
      repeat (40) begin
         send_angles(16'($urandom), 16'($urandom), 16'($urandom));
      end
   endtask

   // sender stops until every result is back, then carries on
   task automatic test_pause_until_drained();
      send_idle_pct = 30;
      rcv_stall_pct = 30;
      repeat (20) begin
         send_angles(pick_angle(), pick_angle(), pick_angle());
      end
      req_tvalid <= 1'b0;
      wait_for_drain();
      repeat (20) begin
         send_angles(pick_angle(), pick_angle(), pick_angle());
      end
   endtask

   initial begin
      fill_sine_quarter();
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_angles();
      test_random_angles(220, 22, 82);
      test_random_angles(220, 82, 22);
      test_random_angles(220, 0, 0);
      test_output_hold_off();
      test_pause_until_drained();

      req_tvalid    <= 1'b0;
      rcv_stall_pct = 0;
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
